// ===== design/pih_pkg.sv =====
package pih_pkg;

    localparam int COORD_BITS = 32;
    localparam int VIDX_BITS  = 3;
    localparam int NUM_RIM    = 6;
    localparam int TOL_BITS   = 16;
    localparam int TOL_SHIFT  = 16;
    localparam int QDEPTH     = 2;
    localparam int DW         = COORD_BITS + 2;
    localparam int MW         = 2 * DW + 2;
    localparam int PW         = 2 * MW;
    localparam int RW         = MW + 3;
    localparam int CNT_BITS   = $clog2(MW + 1);
    localparam int RAW_BITS   = 3 * COORD_BITS;

    typedef enum logic {
        OP_LOAD,
        OP_TEST
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic [VIDX_BITS-1:0]   idx;
        logic [RAW_BITS-1:0]    coords;
    } t_item;

    typedef struct packed {
        logic  vld;
        t_item item;
    } t_head;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
    } t_vec;

    typedef enum logic [1:0] {
        CM_AREA,
        CM_S1,
        CM_S2,
        CM_S3
    } t_cm;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDC,
        S_RDA,
        S_RDB,
        S_MUL1,
        S_MUL2,
        S_SQ,
        S_SQRT,
        S_CHK,
        S_TOL,
        S_NXT
    } t_state;

    function automatic logic signed [DW-1:0] sext(input logic [COORD_BITS-1:0] w);
        return {{(DW - COORD_BITS){w[COORD_BITS-1]}}, w};
    endfunction

    function automatic t_vec vec_of(input logic [RAW_BITS-1:0] raw);
        t_vec v;
        v.x = sext(raw[3*COORD_BITS-1 -: COORD_BITS]);
        v.y = sext(raw[2*COORD_BITS-1 -: COORD_BITS]);
        v.z = sext(raw[COORD_BITS-1 -: COORD_BITS]);
        return v;
    endfunction

    function automatic t_vec vsub(input t_vec a, input t_vec b);
        t_vec v;
        v.x = a.x - b.x;
        v.y = a.y - b.y;
        v.z = a.z - b.z;
        return v;
    endfunction

    function automatic logic signed [DW-1:0] comp(input t_vec v, input logic [1:0] k);
        logic signed [DW-1:0] c;
        unique case (k)
            2'd0:    c = v.x;
            2'd1:    c = v.y;
            default: c = v.z;
        endcase
        return c;
    endfunction

    function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] c);
        logic [DW-1:0] a;
        a = c[DW-1] ? DW'(-c) : DW'(c);
        return MW'(a);
    endfunction

endpackage

// ===== design/pih_front.sv =====
module pih_front import pih_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic                       i_command,
    input  logic [VIDX_BITS-1:0]       i_vertex_index,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic signed [COORD_BITS-1:0] i_coord_z,
    output t_head                      o_head,
    input  logic                       i_pop
);

    t_item r_q [QDEPTH];
    logic  r_wp, r_rp;
    logic  [1:0] r_cnt, n_cnt;
    logic  accept, keep;
    t_item in_item;

    assign o_busy = (r_cnt == 2'(QDEPTH));
    assign accept = i_start && !o_busy;
    assign in_item.op     = t_op'(i_command);
    assign in_item.idx    = i_vertex_index;
    assign in_item.coords = {i_coord_x, i_coord_y, i_coord_z};
    // loads to the unused slot are dropped here
    assign keep = accept && (in_item.op == OP_TEST ||
                             i_vertex_index <= VIDX_BITS'(NUM_RIM));

    assign o_head.vld  = (r_cnt != 2'd0);
    assign o_head.item = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (keep && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!keep && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (keep) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_q[r_wp] <= in_item;
        end
    end

endmodule

// ===== design/pih_mul.sv =====
module pih_mul import pih_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [MW-1:0] i_a,
    input  logic [MW-1:0] i_b,
    output logic          o_done,
    output logic [PW-1:0] o_prod
);

    logic                r_busy, r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [MW-1:0]       r_a;
    logic [PW-1:0]       r_acc, n_acc;
    logic [MW:0]         hi;

    // shift-add, one multiplier bit per cycle
    always_comb begin
        hi    = {1'b0, r_acc[PW-1:MW]} + (r_acc[0] ? {1'b0, r_a} : '0);
        n_acc = {hi, r_acc[MW-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(MW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_acc <= {{MW{1'b0}}, i_b};
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== design/pih_sqrt.sv =====
module pih_sqrt import pih_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [PW-1:0] i_n,
    output logic          o_done,
    output logic [MW-1:0] o_root
);

    logic                r_busy, r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [PW-1:0]       r_n;
    logic [RW-1:0]       r_rem, rem2, trial;
    logic [MW-1:0]       r_root;
    logic                ge;

    // two radicand bits per cycle
    always_comb begin
        rem2  = {r_rem[RW-3:0], r_n[PW-1 -: 2]};
        trial = {{(RW - MW - 2){1'b0}}, r_root, 2'b01};
        ge    = (rem2 >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(MW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n    <= {r_n[PW-3:0], 2'b00};
            r_rem  <= ge ? (rem2 - trial) : rem2;
            r_root <= {r_root[MW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== design/pih_back.sv =====
module pih_back import pih_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_head               i_head,
    output logic                o_pop,
    input  logic                i_cfg_we,
    input  logic [TOL_BITS-1:0] i_cfg_wdata,
    output logic                o_res_valid,
    output logic                o_inside_res
);

    t_state r_state, n_state;
    logic   r_go, n_go;
    logic   [1:0] r_k, n_k;
    t_cm    r_sel, n_sel;
    logic   [VIDX_BITS-1:0] r_tri, n_tri;
    logic   r_res_vld, n_res_vld, r_res, n_res;
    logic   [TOL_BITS-1:0] r_tol;

    logic [RAW_BITS-1:0] r_mem [NUM_RIM + 1];
    logic [RAW_BITS-1:0] r_rd, r_pnt;
    logic [VIDX_BITS-1:0] rd_addr;

    t_vec r_ctr, r_pt, r_ra, r_rb, da, db, va, vb;
    logic signed [MW:0] r_p1, p_sgn, dcp;
    logic        r_sgn;
    logic [MW-1:0] r_m, r_area, r_s1, r_s2, r_s3;
    logic [PW-1:0] r_sum, r_dif, ssum, dif;
    logic [1:0]  ku, kv;
    logic signed [DW-1:0] ca, cb;

    logic          mul_go, mul_done, sqrt_go, sqrt_done, fail, gt;
    logic [MW-1:0] mul_a, mul_b, root;
    logic [PW-1:0] prod;

    pih_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    pih_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_go),
        .i_n     (r_sum),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    assign da = vsub(r_pt, r_ra);
    assign db = vsub(r_pt, r_rb);

    always_comb begin
        unique case (r_sel)
            CM_AREA: begin va = r_ra; vb = r_rb; end
            CM_S1:   begin va = r_pt; vb = r_rb; end
            CM_S2:   begin va = r_pt; vb = r_ra; end
            default: begin va = da;   vb = db;   end
        endcase
        unique case (r_k)
            2'd0:    begin ku = 2'd1; kv = 2'd2; end
            2'd1:    begin ku = 2'd2; kv = 2'd0; end
            default: begin ku = 2'd0; kv = 2'd1; end
        endcase
        if (r_state == S_MUL1) begin
            ca = comp(va, ku);
            cb = comp(vb, kv);
        end else begin
            ca = comp(va, kv);
            cb = comp(vb, ku);
        end
        unique case (r_state)
            S_SQ:    begin mul_a = r_m; mul_b = r_m; end
            S_TOL:   begin mul_a = MW'(r_tol); mul_b = r_area; end
            default: begin mul_a = mag(ca); mul_b = mag(cb); end
        endcase
    end

    assign p_sgn = r_sgn ? -$signed({1'b0, prod[MW-1:0]}) : $signed({1'b0, prod[MW-1:0]});
    assign dcp   = r_p1 - p_sgn;

    always_comb begin
        gt   = (r_s1 > r_area) || (r_s2 > r_area) || (r_s3 > r_area);
        ssum = PW'(r_s1) + PW'(r_s2) + PW'(r_s3);
        dif  = (ssum >= PW'(r_area)) ? (ssum - PW'(r_area)) : (PW'(r_area) - ssum);
    end

    always_comb begin
        n_state   = r_state;
        n_go      = 1'b0;
        n_k       = r_k;
        n_sel     = r_sel;
        n_tri     = r_tri;
        n_res_vld = 1'b0;
        n_res     = 1'b0;
        rd_addr   = '0;
        o_pop     = 1'b0;
        mul_go    = 1'b0;
        sqrt_go   = 1'b0;
        fail      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.vld) begin
                    o_pop = 1'b1;
                    if (i_head.item.op == OP_TEST) begin
                        n_state = S_RDC;
                        n_tri   = '0;
                    end
                end
            end
            S_RDC: begin
                rd_addr = VIDX_BITS'(1);
                n_state = S_RDA;
            end
            S_RDA: begin
                rd_addr = (r_tri == VIDX_BITS'(NUM_RIM - 1)) ? VIDX_BITS'(1)
                                                             : r_tri + VIDX_BITS'(2);
                n_state = S_RDB;
            end
            S_RDB: begin
                n_state = S_MUL1;
                n_go    = 1'b1;
                n_sel   = CM_AREA;
                n_k     = 2'd0;
            end
            S_MUL1: begin
                mul_go = r_go;
                if (mul_done) begin
                    n_state = S_MUL2;
                    n_go    = 1'b1;
                end
            end
            S_MUL2: begin
                mul_go = r_go;
                if (mul_done) begin
                    n_state = S_SQ;
                    n_go    = 1'b1;
                end
            end
            S_SQ: begin
                mul_go = r_go;
                if (mul_done) begin
                    n_go = 1'b1;
                    if (r_k == 2'd2) begin
                        n_state = S_SQRT;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = S_MUL1;
                    end
                end
            end
            S_SQRT: begin
                sqrt_go = r_go;
                if (sqrt_done) begin
                    if (r_sel == CM_AREA && root == '0) begin
                        fail = 1'b1;
                    end else if (r_sel == CM_S3) begin
                        n_state = S_CHK;
                    end else begin
                        n_sel   = t_cm'(r_sel + 2'd1);
                        n_k     = 2'd0;
                        n_go    = 1'b1;
                        n_state = S_MUL1;
                    end
                end
            end
            S_CHK: begin
                if (gt) begin
                    fail = 1'b1;
                end else begin
                    n_state = S_TOL;
                    n_go    = 1'b1;
                end
            end
            S_TOL: begin
                mul_go = r_go;
                if (mul_done) begin
                    if (r_dif <= prod) begin
                        n_res_vld = 1'b1;
                        n_res     = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        fail = 1'b1;
                    end
                end
            end
            S_NXT: begin
                rd_addr = r_tri + VIDX_BITS'(1);
                n_state = S_RDA;
            end
            default: n_state = S_IDLE;
        endcase
        if (fail) begin
            if (r_tri == VIDX_BITS'(NUM_RIM - 1)) begin
                n_res_vld = 1'b1;
                n_state   = S_IDLE;
            end else begin
                n_tri   = r_tri + VIDX_BITS'(1);
                n_state = S_NXT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_go      <= 1'b0;
            r_k       <= 2'd0;
            r_sel     <= CM_AREA;
            r_tri     <= '0;
            r_res_vld <= 1'b0;
            r_tol     <= TOL_BITS'(1);
        end else begin
            r_state   <= n_state;
            r_go      <= n_go;
            r_k       <= n_k;
            r_sel     <= n_sel;
            r_tri     <= n_tri;
            r_res_vld <= n_res_vld;
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
        if (r_state == S_IDLE && i_head.vld && i_head.item.op == OP_LOAD) begin
            r_mem[i_head.item.idx] <= i_head.item.coords;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_res_vld) begin
            r_res <= n_res;
        end
        if (r_state == S_IDLE) begin
            r_pnt <= i_head.item.coords;
        end
        if (r_state == S_RDC) begin
            r_ctr <= vec_of(r_rd);
            r_pt  <= vsub(vec_of(r_pnt), vec_of(r_rd));
            r_sum <= '0;
        end
        if (r_state == S_RDA) begin
            r_ra <= vsub(vec_of(r_rd), r_ctr);
        end
        if (r_state == S_RDB) begin
            r_rb <= vsub(vec_of(r_rd), r_ctr);
        end
        if (mul_go) begin
            r_sgn <= ca[DW-1] ^ cb[DW-1];
        end
        if (mul_done && r_state == S_MUL1) begin
            r_p1 <= p_sgn;
        end
        if (mul_done && r_state == S_MUL2) begin
            r_m <= dcp[MW] ? MW'(-dcp) : MW'(dcp);
        end
        if (mul_done && r_state == S_SQ) begin
            r_sum <= r_sum + prod;
        end
        if (sqrt_go) begin
            r_sum <= '0;
        end
        if (sqrt_done) begin
            unique case (r_sel)
                CM_AREA: r_area <= root;
                CM_S1:   r_s1   <= root;
                CM_S2:   r_s2   <= root;
                default: r_s3   <= root;
            endcase
        end
        if (r_state == S_CHK) begin
            r_dif <= dif << TOL_SHIFT;
        end
    end

    assign o_res_valid  = r_res_vld;
    assign o_inside_res = r_res;

endmodule

// ===== design/point_in_hexagon_test_unit.sv =====
// Channel   Direction  Handshake                 Payload
// item      in         i_start & !o_busy         i_command, i_vertex_index, i_coord_x/y/z
// result    out        o_res_valid, one cycle    o_inside_res
// config    in         i_cfg_we                  i_cfg_wdata (area tolerance)
//
// A load is written to the vertex store straight from the back end's idle state. In a test,
// each fan triangle needs up to 37 shift-add multiplies and 4 root extractions,
// all through one shared multiplier and one root unit.
// A test ends early at the first triangle that holds the point.
// Reset is synchronous, active low; the vertex store is not cleared.
// A two-item queue takes items while the back end works; o_busy means it is full.
module point_in_hexagon_test_unit import pih_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_command,
    input  logic [VIDX_BITS-1:0]         i_vertex_index,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic signed [COORD_BITS-1:0] i_coord_z,
    input  logic                         i_cfg_we,
    input  logic [TOL_BITS-1:0]          i_cfg_wdata,
    output logic                         o_res_valid,
    output logic                         o_inside_res
);

    t_head head;
    logic  pop;

    pih_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_command      (i_command),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .o_head         (head),
        .i_pop          (pop)
    );

    pih_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_res_valid  (o_res_valid),
        .o_inside_res (o_inside_res)
    );

endmodule

// ===== design/pih_checker.sv =====
module pih_checker import pih_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_res_valid
);

    a_no_res_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result strobe right after reset");

    a_not_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_busy)
        else $error("busy right after reset");

    a_res_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("back-to-back result strobes");

    a_busy_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_busy && !i_start) |=> !o_busy)
        else $error("busy without an accepted item");

endmodule

bind point_in_hexagon_test_unit pih_checker u_pih_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_res_valid (o_res_valid)
);
